### rtl/core/tssq_pkg.sv
// Package with the word types, operation codes and task state codes of the scheduler.
`default_nettype none
package tssq_pkg;

    localparam int SLOT_W = 6;

    localparam logic [2:0] KIND_CREATE  = 3'd0;
    localparam logic [2:0] KIND_YIELD   = 3'd1;
    localparam logic [2:0] KIND_BLOCK   = 3'd2;
    localparam logic [2:0] KIND_UNBLOCK = 3'd3;
    localparam logic [2:0] KIND_SLEEP   = 3'd4;
    localparam logic [2:0] KIND_TICK    = 3'd5;

    localparam logic [2:0] ST_RUNNING  = 3'd1;
    localparam logic [2:0] ST_READY    = 3'd2;
    localparam logic [2:0] ST_BLOCKED  = 3'd3;
    localparam logic [2:0] ST_WAITING  = 3'd4;
    localparam logic [2:0] ST_SLEEPING = 3'd5;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_UNUSED = 2'd2;

    localparam logic CFG_TICK_PERIOD = 1'b0;
    localparam logic CFG_IDLE_SLOT   = 1'b1;

    typedef struct packed {
        logic [2:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        priority_req;
        logic [2:0]        block_state;
        logic [31:0]       sleep_ms;
    } in_word_t;

    typedef struct packed {
        logic [SLOT_W-1:0] running_slot;
        logic              switched;
        logic [SLOT_W-1:0] created_slot;
        logic [6:0]        woken_count;
        logic [1:0]        status;
    } out_word_t;

endpackage
`default_nettype wire

### rtl/core/tssq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module tssq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/core/task_scheduler_sleep_queue.sv
// Time-slice task scheduler with a sleep queue, top level.
// Create scans for a free slot; block and unblock write the state, and a block of the
// current task then scans for the next one; yield, sleep and tick scan the task table.
// The block takes one word at a time; the slot scan through the single read port of the
// task table sets the pace, and sleep adds a 32-step restoring divider.
// Reset (aresetn low, synchronous) clears the used marks, the current task, the tick
// counter and the control state; the task table memories are not cleared and need no pass.
`default_nettype none
module task_scheduler_sleep_queue #(
    parameter int TASK_SLOTS = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire tssq_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tssq_pkg::out_word_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [9:0]          cfg_data
);
    import tssq_pkg::*;

    localparam int SW = $clog2(TASK_SLOTS);
    localparam logic [SW-1:0] LAST = SW'(TASK_SLOTS - 1);

    // One-hot sequencer states.
    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_CREATE   = 10'b0000000010,
        S_DIV      = 10'b0000000100,
        S_SLEEP_WR = 10'b0000001000,
        S_SCAN     = 10'b0000010000,
        S_CUR_RD   = 10'b0000100000,
        S_CUR_WR   = 10'b0001000000,
        S_BEST_WR  = 10'b0010000000,
        S_TICK     = 10'b0100000000,
        S_RESP     = 10'b1000000000
    } fsm_t;

    fsm_t state_reg, state_next;
    in_word_t req_reg, req_next;
    out_word_t out_reg, out_next;
    logic m_valid_reg, m_valid_next;
    logic [9:0] tp_reg, tp_next;
    logic [SLOT_W-1:0] idle_reg, idle_next;
    logic used_reg [TASK_SLOTS];
    logic used_next [TASK_SLOTS];
    logic [SW-1:0] cur_reg, cur_next;
    logic cv_reg, cv_next;
    logic [31:0] now_reg, now_next;
    logic [SW:0] scan_cnt_reg, scan_cnt_next;
    logic pipe_vld_reg, pipe_vld_next;
    logic [SW-1:0] pipe_idx_reg, pipe_idx_next;
    logic [SW-1:0] best_reg, best_next;
    logic [31:0] best_ticks_reg, best_ticks_next;
    logic found_reg, found_next;
    logic [31:0] q_reg, q_next;
    logic [10:0] rem_reg, rem_next;
    logic [4:0] div_cnt_reg, div_cnt_next;
    logic switched_reg, switched_next;
    logic [SLOT_W-1:0] created_reg, created_next;
    logic [6:0] woken_reg, woken_next;
    logic [1:0] status_reg, status_next;

    // Task table: state, tick count (or wake tick while asleep) and priority.
    logic st_we, tk_we, pr_we;
    logic [SW-1:0] st_waddr, tk_waddr, pr_waddr, raddr;
    logic [2:0] st_wdata, st_rdata;
    logic [31:0] tk_wdata, tk_rdata;
    logic [7:0] pr_wdata, pr_rdata;

    tssq_ram #(.WIDTH(3), .DEPTH(TASK_SLOTS)) u_state_ram (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(raddr), .rdata(st_rdata)
    );
    tssq_ram #(.WIDTH(32), .DEPTH(TASK_SLOTS)) u_ticks_ram (
        .aclk(aclk), .we(tk_we), .waddr(tk_waddr), .wdata(tk_wdata),
        .raddr(raddr), .rdata(tk_rdata)
    );
    tssq_ram #(.WIDTH(8), .DEPTH(TASK_SLOTS)) u_prio_ram (
        .aclk(aclk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
        .raddr(raddr), .rdata(pr_rdata)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    // Helper values used by several states.
    logic [SW-1:0] in_idx, pidx, cidx;
    logic in_slot_ok, idle_ok, scan_done, cand, wake;
    logic [9:0] period;
    logic [10:0] rem_sh;
    logic [31:0] sleep_len;
    logic [2:0] cur_st;

    always_comb begin
        in_idx     = SW'(s_data.slot);
        in_slot_ok = (32'(s_data.slot) < 32'(TASK_SLOTS)) && used_reg[in_idx];
        idle_ok    = (32'(idle_reg) < 32'(TASK_SLOTS)) && used_reg[SW'(idle_reg)];
        pidx       = pipe_idx_reg;
        cidx       = scan_cnt_reg[SW-1:0];
        scan_done  = pipe_vld_reg && (pipe_idx_reg == LAST);
        period     = (tp_reg == 10'd0) ? 10'd1 : tp_reg;
        rem_sh     = {rem_reg[9:0], q_reg[31]};
        sleep_len  = (q_reg == 32'd0) ? 32'd1 : q_reg;
        // A candidate is a ready, used slot that is not the current task.
        cand = used_reg[pidx] && (st_rdata == ST_READY) && !(cv_reg && pidx == cur_reg);
        wake = used_reg[pidx] && (st_rdata == ST_SLEEPING) && (tk_rdata <= now_reg);
        cur_st = st_rdata;

        state_next      = state_reg;
        req_next        = req_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg;
        tp_next         = tp_reg;
        idle_next       = idle_reg;
        used_next       = used_reg;
        cur_next        = cur_reg;
        cv_next         = cv_reg;
        now_next        = now_reg;
        scan_cnt_next   = scan_cnt_reg;
        pipe_vld_next   = 1'b0;
        pipe_idx_next   = pipe_idx_reg;
        best_next       = best_reg;
        best_ticks_next = best_ticks_reg;
        found_next      = found_reg;
        q_next          = q_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        switched_next   = switched_reg;
        created_next    = created_reg;
        woken_next      = woken_reg;
        status_next     = status_reg;

        st_we = 1'b0; st_waddr = cur_reg; st_wdata = ST_READY;
        tk_we = 1'b0; tk_waddr = cur_reg; tk_wdata = 32'd0;
        pr_we = 1'b0; pr_waddr = cur_reg; pr_wdata = 8'd0;
        raddr = (state_reg == S_CUR_RD) ? cur_reg : cidx;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_index)
                CFG_TICK_PERIOD: tp_next = cfg_data;
                CFG_IDLE_SLOT:   idle_next = cfg_data[SLOT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next      = s_data;
                    switched_next = 1'b0;
                    created_next  = '0;
                    woken_next    = '0;
                    status_next   = STATUS_OK;
                    scan_cnt_next = '0;
                    found_next    = 1'b0;
                    state_next    = S_RESP;
                    case (s_data.kind)
                        KIND_CREATE: state_next = S_CREATE;
                        KIND_YIELD:  state_next = S_SCAN;
                        KIND_BLOCK: begin
                            if (!in_slot_ok) begin
                                status_next = STATUS_UNUSED;
                            end else begin
                                st_we    = 1'b1;
                                st_waddr = in_idx;
                                st_wdata = (s_data.block_state == ST_WAITING) ?
                                           ST_WAITING : ST_BLOCKED;
                                if (cv_reg && cur_reg == in_idx) begin
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        KIND_UNBLOCK: begin
                            if (!in_slot_ok) begin
                                status_next = STATUS_UNUSED;
                            end else begin
                                st_we    = 1'b1;
                                st_waddr = in_idx;
                                st_wdata = ST_READY;
                            end
                        end
                        KIND_SLEEP: begin
                            if (!(cv_reg && used_reg[cur_reg])) begin
                                status_next = STATUS_UNUSED;
                            end else begin
                                q_next       = s_data.sleep_ms;
                                rem_next     = '0;
                                div_cnt_next = '0;
                                state_next   = S_DIV;
                            end
                        end
                        KIND_TICK: begin
                            now_next   = now_reg + 32'd1;
                            state_next = S_TICK;
                        end
                        default: ;
                    endcase
                end
            end

            S_CREATE: begin
                if (!used_reg[cidx]) begin
                    used_next[cidx] = 1'b1;
                    st_we = 1'b1; st_waddr = cidx; st_wdata = ST_READY;
                    tk_we = 1'b1; tk_waddr = cidx; tk_wdata = 32'(req_reg.priority_req);
                    pr_we = 1'b1; pr_waddr = cidx; pr_wdata = req_reg.priority_req;
                    created_next = SLOT_W'(cidx);
                    state_next   = S_RESP;
                end else if (cidx == LAST) begin
                    status_next = STATUS_FULL;
                    state_next  = S_RESP;
                end else begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end

            // Restoring division, one quotient bit per cycle.
            S_DIV: begin
                if (rem_sh >= {1'b0, period}) begin
                    rem_next = rem_sh - {1'b0, period};
                    q_next   = {q_reg[30:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[30:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31) begin
                    state_next = S_SLEEP_WR;
                end
            end

            S_SLEEP_WR: begin
                tk_we = 1'b1; tk_waddr = cur_reg; tk_wdata = now_reg + sleep_len;
                st_we = 1'b1; st_waddr = cur_reg; st_wdata = ST_SLEEPING;
                scan_cnt_next = '0;
                found_next    = 1'b0;
                state_next    = S_SCAN;
            end

            // Reads are issued one slot ahead of the compare.
            S_SCAN: begin
                if (32'(scan_cnt_reg) < 32'(TASK_SLOTS)) begin
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = cidx;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (pipe_vld_reg && cand && (!found_reg || tk_rdata > best_ticks_reg)) begin
                    best_next       = pidx;
                    best_ticks_next = tk_rdata;
                    found_next      = 1'b1;
                end
                if (scan_done) begin
                    if (!found_next && idle_ok) begin
                        best_next  = SW'(idle_reg);
                        found_next = 1'b1;
                    end
                    state_next = cv_reg ? S_CUR_RD : S_BEST_WR;
                end
            end

            S_CUR_RD: state_next = S_CUR_WR;

            // A running outgoing task goes back to ready (other states stay) and refills an empty
            // timeslice; with nothing else to run a running or ready task keeps running.
            S_CUR_WR: begin
                st_we = 1'b1;
                st_waddr = cur_reg;
                st_wdata = (cur_st == ST_RUNNING) ? ST_READY : cur_st;
                if (!found_reg && (cur_st == ST_RUNNING || cur_st == ST_READY)) begin
                    st_wdata = ST_RUNNING;
                end
                if (tk_rdata == 32'd0) begin
                    tk_we = 1'b1; tk_waddr = cur_reg; tk_wdata = 32'(pr_rdata);
                end
                state_next = S_BEST_WR;
            end

            S_BEST_WR: begin
                if (found_reg) begin
                    st_we = 1'b1; st_waddr = best_reg; st_wdata = ST_RUNNING;
                    switched_next = !cv_reg || (best_reg != cur_reg);
                    cur_next = best_reg;
                    cv_next  = 1'b1;
                end
                state_next = S_RESP;
            end

            S_TICK: begin
                if (32'(scan_cnt_reg) < 32'(TASK_SLOTS)) begin
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = cidx;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (pipe_vld_reg && wake) begin
                    st_we = 1'b1; st_waddr = pidx; st_wdata = ST_READY;
                    tk_we = 1'b1; tk_waddr = pidx; tk_wdata = 32'd0;
                    if (woken_reg != 7'd127) begin
                        woken_next = woken_reg + 7'd1;
                    end
                end
                if (scan_done) begin
                    state_next = S_RESP;
                end
            end

            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.running_slot = SLOT_W'(cur_reg);
                    out_next.switched     = switched_reg;
                    out_next.created_slot = created_reg;
                    out_next.woken_count  = woken_reg;
                    out_next.status       = status_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            tp_reg       <= 10'd10;
            idle_reg     <= '0;
            cur_reg      <= '0;
            cv_reg       <= 1'b0;
            now_reg      <= '0;
            pipe_vld_reg <= 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                used_reg[i] <= 1'b0;
            end
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            tp_reg       <= tp_next;
            idle_reg     <= idle_next;
            cur_reg      <= cur_next;
            cv_reg       <= cv_next;
            now_reg      <= now_next;
            pipe_vld_reg <= pipe_vld_next;
            used_reg     <= used_next;
        end
        req_reg        <= req_next;
        out_reg        <= out_next;
        scan_cnt_reg   <= scan_cnt_next;
        pipe_idx_reg   <= pipe_idx_next;
        best_reg       <= best_next;
        best_ticks_reg <= best_ticks_next;
        found_reg      <= found_next;
        q_reg          <= q_next;
        rem_reg        <= rem_next;
        div_cnt_reg    <= div_cnt_next;
        switched_reg   <= switched_next;
        created_reg    <= created_next;
        woken_reg      <= woken_next;
        status_reg     <= status_next;
    end
endmodule
`default_nettype wire
